[design/qsu_pkg.sv]
// ----------------------------------------------------------------------------
// qsu_pkg: shared definitions for the quoted string unescaper
// Decoder modes, result kinds, error codes, the result bundle and the
// character helper functions.
// ----------------------------------------------------------------------------
package qsu_pkg;

	// decoder modes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_BODY = 2'd1;
	localparam logic [1:0] MODE_ESC  = 2'd2;
	localparam logic [1:0] MODE_HEX  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_BAD_HEX    = 3'd0;
	localparam logic [2:0] ERR_BAD_ESCAPE = 3'd1;
	localparam logic [2:0] ERR_NEWLINE    = 3'd2;
	localparam logic [2:0] ERR_END        = 3'd3;
	localparam logic [2:0] ERR_NOT_QUOTE  = 3'd4;

	// characters
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_LF        = 8'h0a;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_U         = 8'h75;

	// utf-8 lead and continuation marks
	localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
	localparam logic [7:0] UTF8_LEAD3 = 8'he0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;

	// up to three results caused by one input word
	typedef struct packed {
		logic [1:0]      cnt;
		logic [1:0]      kind;
		logic [2:0]      err;
		logic [2:0][7:0] data;
	} bundle_t;

	// hex digit value, bit 4 set when the byte is not a hex digit
	function automatic logic [4:0] hex_of(logic [7:0] c);
		case (c) inside
			[8'h30:8'h39]: return {1'b0, c[3:0]};
			[8'h41:8'h46], [8'h61:8'h66]: return {1'b0, c[3:0] + 4'd9};
			default: return 5'h10;
		endcase
	endfunction

	// character of a one-letter escape, zero when unknown
	function automatic logic [7:0] escape_of(logic [7:0] c);
		case (c) inside
			8'h22, 8'h27, 8'h5c, 8'h2f: return c;
			8'h62: return 8'h08;
			8'h66: return 8'h0c;
			8'h6e: return 8'h0a;
			8'h72: return 8'h0d;
			8'h74: return 8'h09;
			default: return 8'h00;
		endcase
	endfunction

endpackage

[design/qsu_if.sv]
// ----------------------------------------------------------------------------
// qsu_if: channels of the quoted string unescaper
// Valid/ready channels for raw text words and for result words.
// ----------------------------------------------------------------------------
interface qsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_req;
	logic       end_of_data;

	modport source (output valid, in_byte, start_req, end_of_data, input ready);
	modport sink (input valid, in_byte, start_req, end_of_data, output ready);
endinterface

interface qsu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [2:0] error_code;
	logic       last;

	modport source (output valid, out_kind, out_byte, error_code, last, input ready);
	modport sink (input valid, out_kind, out_byte, error_code, last, output ready);
endinterface

[design/qsu_decode.sv]
// ----------------------------------------------------------------------------
// qsu_decode: escape decoder
// Holds the string state and turns each accepted text word into a bundle
// of zero to three results in a single pass.
// ----------------------------------------------------------------------------
module qsu_decode (
	input  logic             clk,
	input  logic             arst_n,
	qsu_in_if.sink           text,
	input  logic             room,
	output qsu_pkg::bundle_t bundle,
	output logic             load
);
	import qsu_pkg::*;

	logic [1:0]  mode_q, mode_d;
	logic        single_q, single_d;
	logic [11:0] hex_q, hex_d;
	logic [1:0]  digits_q, digits_d;
	logic        accept;
	logic [7:0]  c;
	logic [7:0]  close_ch;
	logic [4:0]  dig;
	logic [7:0]  esc;
	logic [15:0] cp;

	assign text.ready = room;
	assign accept     = text.valid && room;
	assign load       = accept && (bundle.cnt != 2'd0);
	assign c          = text.in_byte;
	assign close_ch   = single_q ? CH_SQUOTE : CH_DQUOTE;
	assign dig        = hex_of(c);
	assign esc        = escape_of(c);
	assign cp         = {hex_q, dig[3:0]};

	// next state and results of the current word
	always_comb begin
		mode_d   = mode_q;
		single_d = single_q;
		hex_d    = hex_q;
		digits_d = digits_q;
		bundle   = '0;
		if (text.end_of_data) begin
			if (mode_q != MODE_IDLE) begin
				bundle.cnt  = 2'd1;
				bundle.kind = KIND_ERROR;
				bundle.err  = ERR_END;
				mode_d      = MODE_IDLE;
				single_d    = 1'b0;
				hex_d       = '0;
				digits_d    = '0;
			end
		end else if (text.start_req) begin
			hex_d    = '0;
			digits_d = '0;
			single_d = 1'b0;
			mode_d   = MODE_IDLE;
			if (c == CH_DQUOTE || c == CH_SQUOTE) begin
				mode_d   = MODE_BODY;
				single_d = (c == CH_SQUOTE);
			end else begin
				bundle.cnt  = 2'd1;
				bundle.kind = KIND_ERROR;
				bundle.err  = ERR_NOT_QUOTE;
			end
		end else begin
			unique case (mode_q)
				MODE_BODY: begin
					if (c == close_ch) begin
						bundle.cnt  = 2'd1;
						bundle.kind = KIND_CLOSE;
						mode_d      = MODE_IDLE;
						single_d    = 1'b0;
					end else if (c == CH_BACKSLASH) begin
						mode_d = MODE_ESC;
					end else if (c == CH_LF || c == CH_CR) begin
						bundle.cnt  = 2'd1;
						bundle.kind = KIND_ERROR;
						bundle.err  = ERR_NEWLINE;
						mode_d      = MODE_IDLE;
						single_d    = 1'b0;
					end else begin
						bundle.cnt     = 2'd1;
						bundle.data[0] = c;
					end
				end
				MODE_ESC: begin
					if (c == CH_U) begin
						mode_d   = MODE_HEX;
						hex_d    = '0;
						digits_d = '0;
					end else if (esc != 8'h00) begin
						bundle.cnt     = 2'd1;
						bundle.data[0] = esc;
						mode_d         = MODE_BODY;
					end else begin
						bundle.cnt  = 2'd1;
						bundle.kind = KIND_ERROR;
						bundle.err  = ERR_BAD_ESCAPE;
						mode_d      = MODE_IDLE;
						single_d    = 1'b0;
					end
				end
				MODE_HEX: begin
					if (dig[4]) begin
						bundle.cnt  = 2'd1;
						bundle.kind = KIND_ERROR;
						bundle.err  = ERR_BAD_HEX;
						mode_d      = MODE_IDLE;
						single_d    = 1'b0;
						hex_d       = '0;
						digits_d    = '0;
					end else if (digits_q == 2'd3) begin
						// fourth digit: emit the code point as utf-8
						mode_d   = MODE_BODY;
						hex_d    = '0;
						digits_d = '0;
						if (cp[15:7] == '0) begin
							bundle.cnt     = 2'd1;
							bundle.data[0] = cp[7:0];
						end else if (cp[15:11] == '0) begin
							bundle.cnt     = 2'd2;
							bundle.data[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
							bundle.data[1] = UTF8_CONT | {2'b00, cp[5:0]};
						end else begin
							bundle.cnt     = 2'd3;
							bundle.data[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
							bundle.data[1] = UTF8_CONT | {2'b00, cp[11:6]};
							bundle.data[2] = UTF8_CONT | {2'b00, cp[5:0]};
						end
					end else begin
						hex_d    = {hex_q[7:0], dig[3:0]};
						digits_d = digits_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			single_q <= 1'b0;
			hex_q    <= '0;
			digits_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			single_q <= single_d;
			hex_q    <= hex_d;
			digits_q <= digits_d;
		end
	end

	// idle carries no leftover escape state
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (hex_q == '0 && digits_q == '0 && !single_q))
		else $error("idle with leftover state");

	// digits only gather inside a unicode escape
	a_digits_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(digits_q != 2'd0) |-> (mode_q == MODE_HEX))
		else $error("hex digits outside escape");

	// multi-byte output only from a completed unicode escape
	a_multi_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(load && bundle.cnt != 2'd1) |-> (mode_q == MODE_HEX && digits_q == 2'd3))
		else $error("multi-byte bundle outside unicode escape");

endmodule

[design/qsu_emit.sv]
// ----------------------------------------------------------------------------
// qsu_emit: result register and serializer
// Holds one result bundle and hands its words out one per handshake.
// ----------------------------------------------------------------------------
module qsu_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  qsu_pkg::bundle_t bundle,
	input  logic             load,
	output logic             room,
	qsu_out_if.source        result
);
	import qsu_pkg::*;

	bundle_t    bundle_s1;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       take;
	logic       finish;

	assign take   = valid_q && result.ready;
	assign finish = take && (idx_q == bundle_s1.cnt - 2'd1);
	assign room   = !valid_q || finish;

	// result word selection
	assign result.valid      = valid_q;
	assign result.out_kind   = bundle_s1.kind;
	assign result.error_code = bundle_s1.err;
	assign result.out_byte   = bundle_s1.data[idx_q];
	assign result.last       = (idx_q == bundle_s1.cnt - 2'd1);

	// bundle payload
	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s1 <= bundle;
		end
	end

	// occupancy and word index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (finish) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// word index stays inside the held bundle
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q < bundle_s1.cnt))
		else $error("word index beyond bundle");

	// a new bundle only lands in free room
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> room)
		else $error("bundle overwritten");

	// a drained bundle with nothing behind it empties the register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && !load) |=> !valid_q)
		else $error("register not emptied after last word");

endmodule

[design/quoted_string_unescape.sv]
// ----------------------------------------------------------------------------
// quoted_string_unescape: quoted string unescaper
// Decodes quoted string text byte by byte into content bytes, close
// markers and error words.
// ----------------------------------------------------------------------------
// Usage:
//   text   : raw text words (in_byte, start_req, end_of_data), valid/ready.
//   result : result words (out_kind, out_byte, error_code, last),
//            valid/ready; last marks the final word caused by one text word.
// Latency: a text word that causes results shows its first result word on
//   the cycle after it is accepted.
// Throughput: one text word per cycle while the result register has room.
//   A text word is taken in the same cycle that the last word of the held
//   result bundle leaves, so the result register drains and refills without
//   a gap. A unicode escape that ends in two or three utf-8 bytes hands them
//   out one per result handshake; the text channel waits until the last of
//   them leaves. Words with no result pass whenever the register has room.
// Reset: arst_n clears the string state to idle and empties the result
//   register; no result is pending afterwards.
// Stall: while the receiver holds ready low the held result word stays on
//   the port and text ready falls once the register is full.
// ----------------------------------------------------------------------------
module quoted_string_unescape (
	input  logic      clk,
	input  logic      arst_n,
	qsu_in_if.sink    text,
	qsu_out_if.source result
);
	import qsu_pkg::*;

	bundle_t bundle;
	logic    load;
	logic    room;

	qsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.room   (room),
		.bundle (bundle),
		.load   (load)
	);

	qsu_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.bundle (bundle),
		.load   (load),
		.room   (room),
		.result (result)
	);

endmodule
